### design/ctebuf_pkg.sv
// Package for the cursor text edit buffer: field widths, command and status
// codes, and the controller-to-datapath command struct. No dependencies.
`default_nettype none

package ctebuf_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE_LEFT  = 3'd0,
    KIND_MOVE_RIGHT = 3'd1,
    KIND_BACKSPACE  = 3'd2,
    KIND_INSERT     = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;  // request accepted: latch fields, read both stack memories
    logic exec;  // apply the command, register the result
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### design/ctebuf_ctrl.sv
// Controller for the cursor text edit buffer: two-state sequencer that
// accepts a request and issues load/exec commands. Depends on ctebuf_pkg.
`default_nettype none

module ctebuf_ctrl
  import ctebuf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           out_valid,
  output ctrl_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not enter execute");

  a_exec_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("execute did not produce exactly one result");

  a_result_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

endmodule

`default_nettype wire

### design/ctebuf_dp.sv
// Datapath for the cursor text edit buffer: left/right stack memories, stack
// counts and result registers. Depends on ctebuf_pkg; driven by ctebuf_ctrl.
`default_nettype none

module ctebuf_dp
  import ctebuf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CHAR_W-1:0] in_char_value,
  input  wire logic [POS_W-1:0]  in_position,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic [LEN_W-1:0]       out_text_length,
  output logic [LEN_W-1:0]       out_cursor_pos,
  output logic [STAT_W-1:0]      out_status
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

  logic [CHAR_W-1:0] left_mem  [CAPACITY];
  logic [CHAR_W-1:0] right_mem [CAPACITY];

  logic [CNT_W-1:0]  left_count_r, left_count_nxt;
  logic [CNT_W-1:0]  right_count_r, right_count_nxt;

  kind_t             kind_r;
  logic [CHAR_W-1:0] char_r;
  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] left_rd_r, right_rd_r;

  logic [CHAR_W-1:0] out_char_r, res_char;
  logic [LEN_W-1:0]  out_len_r, out_cur_r;
  status_t           out_status_r, res_status;

  logic [CMP_W-1:0]  left_ext, right_ext, tot_ext, in_pos_ext, pos_ext;
  logic [CMP_W-1:0]  left_raddr_w, right_raddr_w;
  logic [CMP_W-1:0]  left_nxt_ext, tot_nxt_ext;
  logic              left_we, right_we;
  logic [CHAR_W-1:0] left_wdata;

  assign left_ext   = CMP_W'(left_count_r);
  assign right_ext  = CMP_W'(right_count_r);
  assign tot_ext    = left_ext + right_ext;
  assign in_pos_ext = CMP_W'(in_position);
  assign pos_ext    = CMP_W'(pos_r);

  // Read addresses use the counts before the command; the right stack is
  // stored top-last, so text position p right of the cursor is total-1-p.
  always_comb begin
    left_raddr_w  = (kind_t'(in_kind) == KIND_MOVE_LEFT)  ? left_ext - 1'b1 : in_pos_ext;
    right_raddr_w = (kind_t'(in_kind) == KIND_MOVE_RIGHT) ? right_ext - 1'b1
                                                          : tot_ext - 1'b1 - in_pos_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= kind_t'(in_kind);
      char_r     <= in_char_value;
      pos_r      <= in_position;
      left_rd_r  <= left_mem[left_raddr_w[ADDR_W-1:0]];
      right_rd_r <= right_mem[right_raddr_w[ADDR_W-1:0]];
    end
  end

  always_comb begin
    left_count_nxt  = left_count_r;
    right_count_nxt = right_count_r;
    left_we         = 1'b0;
    right_we        = 1'b0;
    left_wdata      = char_r;
    res_char        = '0;
    res_status      = ST_DONE;
    case (kind_r)
      KIND_MOVE_LEFT: begin
        if (left_count_r == '0) begin
          res_status = ST_IGNORED;
        end else begin
          left_count_nxt  = left_count_r - 1'b1;
          right_count_nxt = right_count_r + 1'b1;
          right_we        = 1'b1;
        end
      end
      KIND_MOVE_RIGHT: begin
        if (right_count_r == '0) begin
          res_status = ST_IGNORED;
        end else begin
          right_count_nxt = right_count_r - 1'b1;
          left_count_nxt  = left_count_r + 1'b1;
          left_we         = 1'b1;
          left_wdata      = right_rd_r;
        end
      end
      KIND_BACKSPACE: begin
        if (left_count_r == '0) res_status = ST_IGNORED;
        else left_count_nxt = left_count_r - 1'b1;
      end
      KIND_INSERT: begin
        if (tot_ext >= CMP_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          left_count_nxt = left_count_r + 1'b1;
          left_we        = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos_ext >= tot_ext) res_status = ST_OUT_RANGE;
        else res_char = (pos_ext < left_ext) ? left_rd_r : right_rd_r;
      end
      default: res_status = ST_IGNORED;
    endcase
  end

  assign left_nxt_ext = CMP_W'(left_count_nxt);
  assign tot_nxt_ext  = left_nxt_ext + CMP_W'(right_count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.exec && left_we) left_mem[left_count_r[ADDR_W-1:0]] <= left_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && right_we) right_mem[right_count_r[ADDR_W-1:0]] <= left_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r  <= '0;
      right_count_r <= '0;
    end else if (cmd.exec) begin
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_char_r   <= res_char;
      out_len_r    <= tot_nxt_ext[LEN_W-1:0];
      out_cur_r    <= left_nxt_ext[LEN_W-1:0];
      out_status_r <= res_status;
    end
  end

  assign out_char_out    = out_char_r;
  assign out_text_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;
  assign out_status      = out_status_r;

  a_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    tot_ext <= CMP_W'(CAPACITY))
    else $error("stack counts exceed capacity");

  a_read_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (kind_r == KIND_READ) |=> $stable(left_count_r) && $stable(right_count_r))
    else $error("read command changed the stack counts");

  a_counts_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(left_count_r) && $stable(right_count_r))
    else $error("stack counts changed outside execute");

endmodule

`default_nettype wire

### design/cursor_text_edit_buffer_top.sv
// Cursor text edit buffer (gap buffer) top level: one request per command,
// one result strobe after the execute state, from the registered out_valid;
// a new request is taken while that strobe is high, not while busy. The stack
// memory read is registered at acceptance and followed by the update state.
// Synchronous active-low reset empties both stacks; memory contents are kept.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
`default_nettype none

module cursor_text_edit_buffer_top
  import ctebuf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CHAR_W-1:0] in_char_value,
  input  wire logic [POS_W-1:0]  in_position,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_char_out,
  output logic [LEN_W-1:0]       out_text_length,
  output logic [LEN_W-1:0]       out_cursor_pos,
  output logic [STAT_W-1:0]      out_status
);

  ctrl_cmd_t cmd;

  ctebuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ctebuf_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_char_value   (in_char_value),
    .in_position     (in_position),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
